FILE: sv/pixel_left_delta_coder_macros.svh
// Assertion macros used by the coder's top-level RTL file.
`ifndef PIXEL_LEFT_DELTA_CODER_MACROS_SVH
`define PIXEL_LEFT_DELTA_CODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pldc_pkg.sv
`default_nettype none

package pldc_pkg;

  localparam int unsigned PIX_W   = 64;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CDATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ELEMENT_SIZE = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_DIRECTION    = IDX_W'(3);

  typedef enum logic [1:0] {
    ES_8  = 2'd0,
    ES_16 = 2'd1,
    ES_32 = 2'd2,
    ES_64 = 2'd3
  } elem_size_t;

  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } direction_t;

  // Configuration as the datapath sees it, with the geometry already clamped.
  typedef struct packed {
    logic [DIM_W-1:0] width_lim;
    logic [DIM_W-1:0] height_lim;
    elem_size_t       elem_size;
    direction_t       dir;
  } pldc_cfg_t;

  // Position of the next pixel within the plane.
  typedef struct packed {
    logic col_zero;
    logic row_zero;
  } pldc_pos_t;

  function automatic logic [PIX_W-1:0] elem_mask(input elem_size_t es);
    logic [PIX_W-1:0] m;
    begin
      unique case (es)
        ES_8:    m = {{(PIX_W-8){1'b0}}, {8{1'b1}}};
        ES_16:   m = {{(PIX_W-16){1'b0}}, {16{1'b1}}};
        ES_32:   m = {{(PIX_W-32){1'b0}}, {32{1'b1}}};
        default: m = {PIX_W{1'b1}};
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/pldc_pix_if.sv
`default_nettype none

interface pldc_pix_if;
  logic                         valid;
  logic                         ready;
  logic [pldc_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

FILE: sv/pldc_res_if.sv
`default_nettype none

interface pldc_res_if;
  logic                         valid;
  logic                         ready;
  logic [pldc_pkg::PIX_W-1:0]   pixel_out;
  logic                         plane_end;

  modport source (output valid, output pixel_out, output plane_end, input ready);
  modport sink   (input valid, input pixel_out, input plane_end, output ready);
endinterface

`default_nettype wire

FILE: sv/pldc_cfg_if.sv
`default_nettype none

interface pldc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pldc_pkg::IDX_W-1:0]     index;
  logic [pldc_pkg::CDATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/pldc_cfg_regs.sv
`default_nettype none

// Configuration registers. Width and height are clamped here so the datapath
// only ever sees a limit between 1 and the supported maximum.
module pldc_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  pldc_cfg_if.sink             cfg_wr,
  output pldc_pkg::pldc_cfg_t  cfg
);

  localparam int unsigned DW       = pldc_pkg::DIM_W;
  localparam int unsigned DIM_MAXV = (1 << DW) - 1;
  localparam int unsigned WCLIP    = (MAX_WIDTH > DIM_MAXV) ? DIM_MAXV : MAX_WIDTH;
  localparam int unsigned HCLIP    = (MAX_HEIGHT > DIM_MAXV) ? DIM_MAXV : MAX_HEIGHT;

  logic [DW-1:0]           width_r,  width_nxt;
  logic [DW-1:0]           height_r, height_nxt;
  pldc_pkg::elem_size_t    esize_r,  esize_nxt;
  pldc_pkg::direction_t    dir_r,    dir_nxt;
  logic                    wr_en;

  assign cfg_wr.ready = 1'b1;
  assign wr_en        = cfg_wr.valid;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    esize_nxt  = esize_r;
    dir_nxt    = dir_r;
    if (wr_en) begin
      unique case (cfg_wr.index)
        pldc_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_wr.data[DW-1:0];
        pldc_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_wr.data[DW-1:0];
        pldc_pkg::REG_ELEMENT_SIZE: esize_nxt  = pldc_pkg::elem_size_t'(cfg_wr.data[1:0]);
        pldc_pkg::REG_DIRECTION:    dir_nxt    = pldc_pkg::direction_t'(cfg_wr.data[0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(1);
      height_r <= DW'(1);
      esize_r  <= pldc_pkg::ES_8;
      dir_r    <= pldc_pkg::DIR_ENCODE;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      esize_r  <= esize_nxt;
      dir_r    <= dir_nxt;
    end
  end

  // A zero dimension counts as one; anything above the maximum saturates.
  always_comb begin
    priority if (width_r == '0)            cfg.width_lim = DW'(1);
    else if (width_r > DW'(WCLIP))         cfg.width_lim = DW'(WCLIP);
    else                                   cfg.width_lim = width_r;

    priority if (height_r == '0)           cfg.height_lim = DW'(1);
    else if (height_r > DW'(HCLIP))        cfg.height_lim = DW'(HCLIP);
    else                                   cfg.height_lim = height_r;

    cfg.elem_size = esize_r;
    cfg.dir       = dir_r;
  end

endmodule

`default_nettype wire

FILE: sv/pldc_delta_core.sv
`default_nettype none

// Prediction, difference or running sum, and the raster position counters.
// The state always holds uncoded pixels, so the direction may change freely.
module pldc_delta_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pldc_pkg::pldc_cfg_t         cfg,
  input  wire logic                        step,
  input  wire logic [pldc_pkg::PIX_W-1:0]  pixel,
  output      logic [pldc_pkg::PIX_W-1:0]  result,
  output      logic                        plane_end,
  output      pldc_pkg::pldc_pos_t         pos
);

  localparam int unsigned PW       = pldc_pkg::PIX_W;
  localparam int unsigned DW       = pldc_pkg::DIM_W;
  localparam int unsigned DIM_MAXV = (1 << DW) - 1;
  localparam int unsigned WCLIP    = (MAX_WIDTH > DIM_MAXV) ? DIM_MAXV : MAX_WIDTH;
  localparam int unsigned HCLIP    = (MAX_HEIGHT > DIM_MAXV) ? DIM_MAXV : MAX_HEIGHT;
  localparam int unsigned CW       = $clog2(WCLIP);
  localparam int unsigned RW       = $clog2(HCLIP);

  logic [PW-1:0] left_r,  left_nxt;
  logic [PW-1:0] rstart_r, rstart_nxt;
  logic [CW-1:0] col_r,   col_nxt;
  logic [RW-1:0] row_r,   row_nxt;

  logic [PW-1:0] mask, x, pred, y, raw;
  logic          col_zero, row_zero, last_col, last_row;

  assign mask     = pldc_pkg::elem_mask(cfg.elem_size);
  assign x        = pixel & mask;
  assign col_zero = (col_r == '0);
  assign row_zero = (row_r == '0);

  // A counter at or past a limit counts as the last column or row, so a
  // geometry change in mid plane wraps the plane at once.
  assign last_col = ((DW+1)'(col_r) + (DW+1)'(1)) >= {1'b0, cfg.width_lim};
  assign last_row = ((DW+1)'(row_r) + (DW+1)'(1)) >= {1'b0, cfg.height_lim};

  always_comb begin
    priority if (col_zero && row_zero) pred = '0;
    else if (col_zero)                 pred = rstart_r & mask;
    else                               pred = left_r & mask;

    if (cfg.dir == pldc_pkg::DIR_DECODE) begin
      y   = (x + pred) & mask;
      raw = y;
    end else begin
      y   = (x - pred) & mask;
      raw = x;
    end
  end

  assign result    = y;
  assign plane_end = last_col && last_row;
  assign pos       = '{col_zero: col_zero, row_zero: row_zero};

  always_comb begin
    left_nxt   = left_r;
    rstart_nxt = rstart_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (step) begin
      left_nxt = raw;
      if (col_zero) begin
        rstart_nxt = raw;
      end
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      rstart_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      left_r   <= left_nxt;
      rstart_r <= rstart_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pixel_left_delta_coder.sv
// Channel   Port     Dir  Payload
// input     in_pix   in   pixel_in (64)
// result    out_res  out  pixel_out (64), plane_end (1)
// config    cfg_wr   in   index (8), data (16)
//
// One word is taken and one word is given per clock in steady state, while the
// result port does not stall. A taken pixel passes through the input register
// and then the result register, from which it is read out.
// The rate is set by the left-neighbor loop: one masked 64-bit add or
// subtract plus the counter compare sits between the input register and the
// state and result registers.
// Reset is synchronous and active low; it empties both stages and returns the
// registers to width 1, height 1, 8-bit pixels and encode.
// A stall at the result port holds the result register, then the input
// register, and only then drops in_pix.ready.
`default_nettype none

`include "pixel_left_delta_coder_macros.svh"

module pixel_left_delta_coder #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pldc_pix_if.sink   in_pix,
  pldc_res_if.source out_res,
  pldc_cfg_if.sink   cfg_wr
);

  localparam int unsigned PW = pldc_pkg::PIX_W;

  pldc_pkg::pldc_cfg_t cfg;
  pldc_pkg::pldc_pos_t pos;

  // Input register.
  logic          s1_valid_r, s1_valid_nxt;
  logic [PW-1:0] s1_pixel_r, s1_pixel_nxt;

  // Result register.
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_pixel_r, out_pixel_nxt;
  logic          out_end_r,   out_end_nxt;

  logic          advance;
  logic          in_take;
  logic [PW-1:0] core_pixel;
  logic          core_end;

  // Conditions watched by the assertions below.
  logic          full_stall;
  logic          s1_stuck;
  logic          plane_done;
  logic          at_origin;

  pldc_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // The held word moves on when the result register is empty or being read.
  assign advance      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_pix.ready = !s1_valid_r || advance;
  assign in_take      = in_pix.valid && in_pix.ready;

  pldc_delta_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (advance),
    .pixel     (s1_pixel_r),
    .result    (core_pixel),
    .plane_end (core_end),
    .pos       (pos)
  );

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    s1_pixel_nxt = in_take ? in_pix.pixel_in : s1_pixel_r;

    out_valid_nxt = advance ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);
    out_pixel_nxt = advance ? core_pixel : out_pixel_r;
    out_end_nxt   = advance ? core_end : out_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_pixel_r  <= s1_pixel_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_end_r   <= out_end_nxt;
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.pixel_out = out_pixel_r;
  assign out_res.plane_end = out_end_r;

  assign full_stall = s1_valid_r && out_valid_r && !out_res.ready;
  assign s1_stuck   = s1_valid_r && !advance;
  assign plane_done = advance && core_end;
  assign at_origin  = pos.col_zero && pos.row_zero;

  // Both stages full and the result stalled: no new word may come in.
  `PLDC_ASSERT_NOW(a_full_blocks_input, clk, rst_n, full_stall, !in_pix.ready, "input taken when full")
  // A held word that cannot move must still be there next cycle.
  `PLDC_ASSERT_NEXT(a_held_word_stays, clk, rst_n, s1_stuck, s1_valid_r, "held word was lost")
  // Every word that leaves the input register lands in the result register.
  `PLDC_ASSERT_NEXT(a_result_lands, clk, rst_n, advance, out_valid_r, "result register left empty")
  // The last pixel of a plane sends the counters back to the top-left corner.
  `PLDC_ASSERT_NEXT(a_plane_wraps, clk, rst_n, plane_done, at_origin, "counters did not restart")

endmodule

`default_nettype wire
